// ===== design/segx_pkg.sv =====
// Shared types and defaults for the segment intersection unit.
package segx_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned FIELD_BITS     = 16;
  localparam int unsigned POINT_BITS     = 32;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_PROPER   = 2'd1,
    KIND_ENDPOINT = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] a_start_x;
    logic signed [FIELD_BITS-1:0] a_start_y;
    logic signed [FIELD_BITS-1:0] a_end_x;
    logic signed [FIELD_BITS-1:0] a_end_y;
    logic signed [FIELD_BITS-1:0] b_start_x;
    logic signed [FIELD_BITS-1:0] b_start_y;
    logic signed [FIELD_BITS-1:0] b_end_x;
    logic signed [FIELD_BITS-1:0] b_end_y;
  } segx_in_t;

  typedef struct packed {
    kind_t                        cross_kind;
    logic signed [POINT_BITS-1:0] cross_x;
    logic signed [POINT_BITS-1:0] cross_y;
  } segx_out_t;

endpackage

// ===== design/segment_intersection_unit.sv =====
// The result strobe follows the accepting edge through stages 1 to 6, the divider's
//   entry register and its one-bit-per-stage chain, and the output register.
// Throughput: one segment pair per cycle; busy stays low, start is never refused.
// Reset: rst_n (synchronous, active low) clears every stage valid bit and the
//   strobe; data registers are not reset. The receiver cannot stall the output.
module segment_intersection_unit #(
  parameter int unsigned COORD_BITS = segx_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = segx_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  segx_pkg::segx_in_t  in_data,
  output logic                out_valid,
  output segx_pkg::segx_out_t out_data
);
  import segx_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DFW = C + 1;           // coordinate difference
  localparam int PRW = 2 * DFW;         // product of two differences
  localparam int CW  = PRW + 1;         // cross product, determinant
  localparam int PW  = 2 * C + 1;       // line constant x1*y2 - x2*y1
  localparam int MPW = DFW + PW;
  localparam int NW  = MPW + 1;         // numerator before scaling
  localparam int QB  = C + F;           // quotient bits kept
  localparam int RW  = CW + 1;          // partial remainder
  localparam int QS  = QB + 1;          // signed point width
  localparam int SW  = (QS > 33) ? QS : 33;

  localparam logic signed [SW-1:0] SAT_MAX = SW'(33'sh0_7fff_ffff);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(33'sh1_8000_0000);

  typedef logic signed [C-1:0] crd_t;

  typedef struct packed {
    logic hit;
    crd_t ex;
    crd_t ey;
    crd_t xlo;
    crd_t xhi;
    crd_t ylo;
    crd_t yhi;
    logic detnz;
    logic negx;
    logic negy;
    logic ovx;
    logic ovy;
  } side_t;

  function automatic crd_t sx(input logic signed [FIELD_BITS-1:0] v);
    logic [63:0] z;
    z = {48'b0, v};
    return z[C-1:0];
  endfunction

  function automatic crd_t mnc(input crd_t a, input crd_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic crd_t mxc(input crd_t a, input crd_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [POINT_BITS-1:0] sat(input logic signed [QS-1:0] v);
    logic signed [SW-1:0] w;
    w = SW'(v);
    if (w > SAT_MAX) begin
      return SAT_MAX[POINT_BITS-1:0];
    end else if (w < SAT_MIN) begin
      return SAT_MIN[POINT_BITS-1:0];
    end
    return w[POINT_BITS-1:0];
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // ---------------- stage 1: capture coordinates
  logic s1_vld_r;
  crd_t x1_r, y1_r, x2_r, y2_r, u1_r, v1_r, u2_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
    x1_r <= sx(in_data.a_start_x);
    y1_r <= sx(in_data.a_start_y);
    x2_r <= sx(in_data.a_end_x);
    y2_r <= sx(in_data.a_end_y);
    u1_r <= sx(in_data.b_start_x);
    v1_r <= sx(in_data.b_start_y);
    u2_r <= sx(in_data.b_end_x);
    v2_r <= sx(in_data.b_end_y);
  end

  // ---------------- stage 2: differences, equality and box flags
  logic s2_vld_r;
  logic signed [DFW-1:0] dax_r, day_r, dbx_r, dby_r;
  logic signed [DFW-1:0] ptx_r [4];
  logic signed [DFW-1:0] pty_r [4];
  logic [3:0] eq_r, inb_r;
  logic dega_r, degb_r;
  crd_t x1b_r, y1b_r, x2b_r, y2b_r, u1b_r, v1b_r, u2b_r, v2b_r;
  crd_t xlo_r, xhi_r, ylo_r, yhi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    dax_r  <= DFW'(x2_r) - DFW'(x1_r);
    day_r  <= DFW'(y2_r) - DFW'(y1_r);
    dbx_r  <= DFW'(u2_r) - DFW'(u1_r);
    dby_r  <= DFW'(v2_r) - DFW'(v1_r);
    ptx_r[0] <= DFW'(u1_r) - DFW'(x1_r);
    pty_r[0] <= DFW'(v1_r) - DFW'(y1_r);
    ptx_r[1] <= DFW'(u2_r) - DFW'(x1_r);
    pty_r[1] <= DFW'(v2_r) - DFW'(y1_r);
    ptx_r[2] <= DFW'(x1_r) - DFW'(u1_r);
    pty_r[2] <= DFW'(y1_r) - DFW'(v1_r);
    ptx_r[3] <= DFW'(x2_r) - DFW'(u1_r);
    pty_r[3] <= DFW'(y2_r) - DFW'(v1_r);
    eq_r[0] <= (u1_r == x1_r && v1_r == y1_r) || (u1_r == x2_r && v1_r == y2_r);
    eq_r[1] <= (u2_r == x1_r && v2_r == y1_r) || (u2_r == x2_r && v2_r == y2_r);
    eq_r[2] <= (x1_r == u1_r && y1_r == v1_r) || (x1_r == u2_r && y1_r == v2_r);
    eq_r[3] <= (x2_r == u1_r && y2_r == v1_r) || (x2_r == u2_r && y2_r == v2_r);
    inb_r[0] <= (u1_r >= mnc(x1_r, x2_r)) && (u1_r <= mxc(x1_r, x2_r)) &&
                (v1_r >= mnc(y1_r, y2_r)) && (v1_r <= mxc(y1_r, y2_r));
    inb_r[1] <= (u2_r >= mnc(x1_r, x2_r)) && (u2_r <= mxc(x1_r, x2_r)) &&
                (v2_r >= mnc(y1_r, y2_r)) && (v2_r <= mxc(y1_r, y2_r));
    inb_r[2] <= (x1_r >= mnc(u1_r, u2_r)) && (x1_r <= mxc(u1_r, u2_r)) &&
                (y1_r >= mnc(v1_r, v2_r)) && (y1_r <= mxc(v1_r, v2_r));
    inb_r[3] <= (x2_r >= mnc(u1_r, u2_r)) && (x2_r <= mxc(u1_r, u2_r)) &&
                (y2_r >= mnc(v1_r, v2_r)) && (y2_r <= mxc(v1_r, v2_r));
    dega_r <= (x1_r == x2_r) && (y1_r == y2_r);
    degb_r <= (u1_r == u2_r) && (v1_r == v2_r);
    xlo_r  <= mxc(mnc(x1_r, x2_r), mnc(u1_r, u2_r));
    xhi_r  <= mnc(mxc(x1_r, x2_r), mxc(u1_r, u2_r));
    ylo_r  <= mxc(mnc(y1_r, y2_r), mnc(v1_r, v2_r));
    yhi_r  <= mnc(mxc(y1_r, y2_r), mxc(v1_r, v2_r));
    x1b_r <= x1_r; y1b_r <= y1_r; x2b_r <= x2_r; y2b_r <= y2_r;
    u1b_r <= u1_r; v1b_r <= v1_r; u2b_r <= u2_r; v2b_r <= v2_r;
  end

  // ---------------- stage 3: products
  logic s3_vld_r;
  logic signed [PRW-1:0] cpa_r [4];
  logic signed [PRW-1:0] cpb_r [4];
  logic signed [PRW-1:0] dt1_r, dt2_r;
  logic signed [2*C-1:0] pp1_r, pp2_r, qq1_r, qq2_r;
  logic signed [DFW-1:0] dax3_r, day3_r, dbx3_r, dby3_r;
  logic [3:0] eq3_r, inb3_r;
  logic dega3_r, degb3_r;
  side_t side3_nxt;
  side_t side3_r;
  crd_t u1c_r, v1c_r, u2c_r, v2c_r, x1c_r, y1c_r, x2c_r, y2c_r;

  always_comb begin
    side3_nxt     = '0;
    side3_nxt.xlo = xlo_r;
    side3_nxt.xhi = xhi_r;
    side3_nxt.ylo = ylo_r;
    side3_nxt.yhi = yhi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    for (int i = 0; i < 2; i++) begin
      cpa_r[i] <= dax_r * pty_r[i];
      cpb_r[i] <= day_r * ptx_r[i];
    end
    for (int i = 2; i < 4; i++) begin
      cpa_r[i] <= dbx_r * pty_r[i];
      cpb_r[i] <= dby_r * ptx_r[i];
    end
    dt1_r <= dax_r * dby_r;
    dt2_r <= day_r * dbx_r;
    pp1_r <= x1b_r * y2b_r;
    pp2_r <= x2b_r * y1b_r;
    qq1_r <= u1b_r * v2b_r;
    qq2_r <= u2b_r * v1b_r;
    dax3_r <= dax_r; day3_r <= day_r; dbx3_r <= dbx_r; dby3_r <= dby_r;
    eq3_r <= eq_r; inb3_r <= inb_r; dega3_r <= dega_r; degb3_r <= degb_r;
    side3_r <= side3_nxt;
    u1c_r <= u1b_r; v1c_r <= v1b_r; u2c_r <= u2b_r; v2c_r <= v2b_r;
    x1c_r <= x1b_r; y1c_r <= y1b_r; x2c_r <= x2b_r; y2c_r <= y2b_r;
  end

  // ---------------- stage 4: endpoint decision, determinant, line constants
  logic [3:0] on_seg;
  side_t side4_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      on_seg[i] = eq3_r[i] |
                  (~((i < 2) ? dega3_r : degb3_r) & (cpa_r[i] == cpb_r[i]) & inb3_r[i]);
    end
    side4_nxt     = side3_r;
    side4_nxt.hit = |on_seg;
    priority if (on_seg[0]) begin
      side4_nxt.ex = u1c_r; side4_nxt.ey = v1c_r;
    end else if (on_seg[1]) begin
      side4_nxt.ex = u2c_r; side4_nxt.ey = v2c_r;
    end else if (on_seg[2]) begin
      side4_nxt.ex = x1c_r; side4_nxt.ey = y1c_r;
    end else begin
      side4_nxt.ex = x2c_r; side4_nxt.ey = y2c_r;
    end
  end

  logic s4_vld_r;
  side_t side4_r;
  logic signed [CW-1:0] det4_r;
  logic signed [PW-1:0] lp_r, lq_r;
  logic signed [DFW-1:0] dax4_r, day4_r, dbx4_r, dby4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    side4_r <= side4_nxt;
    det4_r  <= CW'(dt1_r) - CW'(dt2_r);
    lp_r    <= PW'(pp1_r) - PW'(pp2_r);
    lq_r    <= PW'(qq1_r) - PW'(qq2_r);
    dax4_r <= dax3_r; day4_r <= day3_r; dbx4_r <= dbx3_r; dby4_r <= dby3_r;
  end

  // ---------------- stage 5: numerator products
  // nx = dax*Q - dbx*P, ny = day*Q - dby*P
  logic s5_vld_r;
  side_t side5_r;
  logic signed [CW-1:0] det5_r;
  logic signed [MPW-1:0] mx1_r, mx2_r, my1_r, my2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
    end
    side5_r <= side4_r;
    det5_r  <= det4_r;
    mx1_r   <= dax4_r * lq_r;
    mx2_r   <= dbx4_r * lp_r;
    my1_r   <= day4_r * lq_r;
    my2_r   <= dby4_r * lp_r;
  end

  // ---------------- stage 6: numerators, magnitudes and signs
  logic signed [NW-1:0] nx, ny;
  side_t side6_nxt;

  always_comb begin
    nx              = NW'(mx1_r) - NW'(mx2_r);
    ny              = NW'(my1_r) - NW'(my2_r);
    side6_nxt       = side5_r;
    side6_nxt.detnz = (det5_r != '0);
    side6_nxt.negx  = nx[NW-1] ^ det5_r[CW-1];
    side6_nxt.negy  = ny[NW-1] ^ det5_r[CW-1];
  end

  logic s6_vld_r;
  side_t side6_r;
  logic [NW-1:0] nmx_r, nmy_r;
  logic [CW-1:0] dmag6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else begin
      s6_vld_r <= s5_vld_r;
    end
    side6_r <= side6_nxt;
    nmx_r   <= nx[NW-1] ? NW'(-nx) : NW'(nx);
    nmy_r   <= ny[NW-1] ? NW'(-ny) : NW'(ny);
    dmag6_r <= det5_r[CW-1] ? CW'(-det5_r) : CW'(det5_r);
  end

  // ---------------- divider: entry at index 0, one quotient bit per stage
  logic          dv_vld_r [QB+1];
  side_t         dv_side_r [QB+1];
  logic [CW-1:0] dv_d_r [QB+1];
  logic [RW-1:0] rx_r [QB+1];
  logic [RW-1:0] ry_r [QB+1];
  logic [QB-1:0] lx_r [QB+1];
  logic [QB-1:0] ly_r [QB+1];
  logic [QB-1:0] qx_r [QB+1];
  logic [QB-1:0] qy_r [QB+1];

  side_t side7_nxt;
  logic [NW-1:0] dshift;

  always_comb begin
    dshift        = NW'(dmag6_r) << C;
    side7_nxt     = side6_r;
    // quotient would not fit in QB bits, so it lies off both boxes
    side7_nxt.ovx = (nmx_r >= dshift);
    side7_nxt.ovy = (nmy_r >= dshift);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else begin
      dv_vld_r[0] <= s6_vld_r;
    end
    dv_side_r[0] <= side7_nxt;
    dv_d_r[0]    <= dmag6_r;
    rx_r[0]      <= RW'(nmx_r[NW-1:C]);
    ry_r[0]      <= RW'(nmy_r[NW-1:C]);
    lx_r[0]      <= QB'(nmx_r[C-1:0]) << F;
    ly_r[0]      <= QB'(nmy_r[C-1:0]) << F;
    qx_r[0]      <= '0;
    qy_r[0]      <= '0;
  end

  for (genvar k = 1; k <= QB; k++) begin : g_div
    logic [RW-1:0] tx, ty;
    logic          bx, by;

    always_comb begin
      tx = {rx_r[k-1][RW-2:0], lx_r[k-1][QB-1]};
      ty = {ry_r[k-1][RW-2:0], ly_r[k-1][QB-1]};
      bx = (tx >= RW'(dv_d_r[k-1]));
      by = (ty >= RW'(dv_d_r[k-1]));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[k] <= 1'b0;
      end else begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
      dv_side_r[k] <= dv_side_r[k-1];
      dv_d_r[k]    <= dv_d_r[k-1];
      rx_r[k]      <= bx ? (tx - RW'(dv_d_r[k-1])) : tx;
      ry_r[k]      <= by ? (ty - RW'(dv_d_r[k-1])) : ty;
      lx_r[k]      <= lx_r[k-1] << 1;
      ly_r[k]      <= ly_r[k-1] << 1;
      qx_r[k]      <= {qx_r[k-1][QB-2:0], bx};
      qy_r[k]      <= {qy_r[k-1][QB-2:0], by};
    end
  end

  // ---------------- final stage: sign, box test, select, saturate
  side_t             fs;
  logic signed [QS-1:0] cx, cy, px, py;
  logic              proper;
  kind_t             kind;
  segx_out_t         out_nxt;

  always_comb begin
    fs = dv_side_r[QB];
    cx = fs.negx ? -QS'(qx_r[QB]) : QS'(qx_r[QB]);
    cy = fs.negy ? -QS'(qy_r[QB]) : QS'(qy_r[QB]);
    proper = fs.detnz && !fs.ovx && !fs.ovy &&
             (cx >= (QS'(fs.xlo) <<< F)) && (cx <= (QS'(fs.xhi) <<< F)) &&
             (cy >= (QS'(fs.ylo) <<< F)) && (cy <= (QS'(fs.yhi) <<< F));
    if (fs.hit) begin
      kind = KIND_ENDPOINT;
      px   = QS'(fs.ex) <<< F;
      py   = QS'(fs.ey) <<< F;
    end else begin
      kind = proper ? KIND_PROPER : KIND_NONE;
      px   = cx;
      py   = cy;
    end
    out_nxt.cross_kind = kind;
    out_nxt.cross_x    = (kind == KIND_NONE) ? '0 : sat(px);
    out_nxt.cross_y    = (kind == KIND_NONE) ? '0 : sat(py);
  end

  logic      out_valid_r;
  segx_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld_r[QB];
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, QB + 8) |-> (out_valid == $past(accept, QB + 8)))
    else $error("result beat does not follow its input beat at fixed latency");

  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.cross_kind == KIND_NONE) |->
      (out_data.cross_x == '0 && out_data.cross_y == '0))
    else $error("no-crossing beat carries a nonzero point");

  a_proper_det: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_vld_r[QB] && !fs.hit && proper) |-> (fs.detnz && dv_d_r[QB] != '0))
    else $error("proper crossing reported with zero determinant");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (s1_vld_r && !busy))
    else $error("accepted beat did not enter the pipeline");

endmodule
